/* hdl/signed_add_sub_booth_mul_div_alu_unit_assert.svh */
// ----------------------------------------------------------------------------
// signed_add_sub_booth_mul_div_alu_unit_assert.svh
// Assertion macros used by the checker file sabmd_chk.
// ----------------------------------------------------------------------------
`ifndef SIGNED_ADD_SUB_BOOTH_MUL_DIV_ALU_UNIT_ASSERT_SVH
`define SIGNED_ADD_SUB_BOOTH_MUL_DIV_ALU_UNIT_ASSERT_SVH

// same-cycle implication, masked while reset is asserted
`define SABMD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked while reset is asserted
`define SABMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/sabmd_pkg.sv */
// ----------------------------------------------------------------------------
// sabmd_pkg
// Types, codes and the shared Booth / restoring-divide step of the ALU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sabmd_pkg;

  localparam int W               = 16;
  localparam int STEPS_PER_STAGE = 4;
  localparam int ITER_STAGES     = W / STEPS_PER_STAGE;

  // operation codes
  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_SUB = 2'd1;
  localparam logic [1:0] KIND_MUL = 2'd2;
  localparam logic [1:0] KIND_DIV = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OVF = 2'd1;
  localparam logic [1:0] ST_NEG = 2'd2;
  localparam logic [1:0] ST_DIV = 2'd3;

  // iterative datapath word: multiply uses {hi, lo, qm1} as the Booth shift
  // register with aux the multiplicand; divide uses hi as partial remainder,
  // lo as dividend/quotient shifter and aux as divisor magnitude
  typedef struct packed {
    logic [W:0]   acc_hi;
    logic [W-1:0] acc_lo;
    logic         qm1;
    logic [W:0]   aux;
  } work_t;

  typedef struct packed {
    logic [1:0]   kind;
    logic [1:0]   status;
    logic [W-1:0] sum_lo;
    logic         neg_q;
    logic         neg_r;
    work_t        work;
  } stage_t;

  function automatic work_t iter_step(input logic is_mul, input work_t w);
    work_t      n;
    logic [W:0] h;
    logic [W:0] r;
    n = w;
    h = w.acc_hi;
    r = '0;
    if (is_mul) begin
      case ({w.acc_lo[0], w.qm1})
        2'b01:   h = w.acc_hi + w.aux;
        2'b10:   h = w.acc_hi - w.aux;
        default: h = w.acc_hi;
      endcase
      n.qm1    = w.acc_lo[0];
      n.acc_lo = {h[0], w.acc_lo[W-1:1]};
      n.acc_hi = {h[W], h[W:1]};
    end else begin
      r        = {w.acc_hi[W-1:0], w.acc_lo[W-1]};
      n.acc_lo = {w.acc_lo[W-2:0], 1'b0};
      if (r >= w.aux) begin
        r           = r - w.aux;
        n.acc_lo[0] = 1'b1;
      end
      n.acc_hi = r;
    end
    return n;
  endfunction

endpackage

/* hdl/sabmd_if.sv */
// ----------------------------------------------------------------------------
// sabmd_if
// Valid/ready channels for operation words and result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sabmd_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [15:0] operand_a;
  logic signed [15:0] operand_b;

  modport source (output valid, kind, operand_a, operand_b, input ready);
  modport sink   (input valid, kind, operand_a, operand_b, output ready);
endinterface

interface sabmd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] value_low;
  logic [15:0] value_high;
  logic [1:0]  status;

  modport source (output valid, value_low, value_high, status, input ready);
  modport sink   (input valid, value_low, value_high, status, output ready);
endinterface

/* hdl/signed_add_sub_booth_mul_div_alu_unit.sv */
// ----------------------------------------------------------------------------
// signed_add_sub_booth_mul_div_alu_unit
// 16-bit signed ALU: add, subtract, Booth multiply, restoring divide.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one operation word: kind, operand_a, operand_b.
//   out_ch returns one result word per operation, in order:
//   value_low, value_high, status. Both are valid/ready channels; a word
//   moves on a rising edge with valid and ready high.
// Pipeline: one operand-prep register, four iteration stages and one
//   output register, for every kind.
// Throughput: one word per cycle unless out_ch stalls. Each iteration
//   stage runs four steps of the shared Booth / restoring-divide step,
//   so sixteen steps span four stages and a new word can follow each cycle.
// Stalls: each stage has its own valid bit and moves when its successor
//   is empty or moving, so a stalled receiver fills bubbles first and
//   in_ch.ready only drops once every stage holds a word.
// Reset: synchronous, active low; clears all valid bits, nothing else.
// Errors (overflow, unnegatable subtrahend, divide error) zero both values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module signed_add_sub_booth_mul_div_alu_unit (
  input  logic      clk,
  input  logic      rst_n,
  sabmd_in_if.sink  in_ch,
  sabmd_out_if.source out_ch
);
  import sabmd_pkg::*;

  localparam logic [W-1:0] WORD_MIN = {1'b1, {(W-1){1'b0}}};

  // ---- operand prep ------------------------------------------------------
  stage_t     prep_nxt;
  logic [W:0] a_ext, b_ext, sum_ext, diff_ext;
  logic [W-1:0] a_raw, b_raw, abs_a, abs_b;

  always_comb begin
    a_raw    = in_ch.operand_a;
    b_raw    = in_ch.operand_b;
    a_ext    = {a_raw[W-1], a_raw};
    b_ext    = {b_raw[W-1], b_raw};
    sum_ext  = a_ext + b_ext;
    diff_ext = a_ext - b_ext;
    abs_a    = a_raw[W-1] ? (~a_raw + 1'b1) : a_raw;
    abs_b    = b_raw[W-1] ? (~b_raw + 1'b1) : b_raw;

    prep_nxt        = '0;
    prep_nxt.kind   = in_ch.kind;
    prep_nxt.status = ST_OK;
    case (in_ch.kind)
      KIND_ADD: begin
        prep_nxt.sum_lo = sum_ext[W-1:0];
        if (sum_ext[W] != sum_ext[W-1]) prep_nxt.status = ST_OVF;
      end
      KIND_SUB: begin
        // a - b matches a + (-b) whenever b can be negated
        prep_nxt.sum_lo = diff_ext[W-1:0];
        if (b_raw == WORD_MIN) begin
          prep_nxt.status = ST_NEG;
        end else if (diff_ext[W] != diff_ext[W-1]) begin
          prep_nxt.status = ST_OVF;
        end
      end
      KIND_MUL: begin
        prep_nxt.work.acc_lo = b_raw;
        prep_nxt.work.aux    = a_ext;
      end
      KIND_DIV: begin
        // divide magnitudes, fix signs at the end
        prep_nxt.work.acc_lo = abs_a;
        prep_nxt.work.aux    = {1'b0, abs_b};
        prep_nxt.neg_q       = a_raw[W-1] ^ b_raw[W-1];
        prep_nxt.neg_r       = a_raw[W-1];
        if (b_raw == '0 || (a_raw == WORD_MIN && b_raw == '1)) begin
          prep_nxt.status = ST_DIV;
        end
      end
      default: prep_nxt.status = ST_OK;
    endcase
  end

  // ---- pipeline: index 0 is the prep register ----------------------------
  logic   pipe_valid [0:ITER_STAGES];
  logic   pipe_ready [0:ITER_STAGES];
  stage_t pipe_data  [0:ITER_STAGES];

  logic   prep_valid_r;
  stage_t prep_r;

  assign in_ch.ready = !prep_valid_r || pipe_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      prep_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      prep_r <= prep_nxt;
    end
  end

  assign pipe_valid[0] = prep_valid_r;
  assign pipe_data[0]  = prep_r;

  for (genvar k = 0; k < ITER_STAGES; k++) begin : g_iter
    sabmd_iter_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (pipe_valid[k]),
      .up_ready (pipe_ready[k]),
      .up_data  (pipe_data[k]),
      .dn_valid (pipe_valid[k+1]),
      .dn_ready (pipe_ready[k+1]),
      .dn_data  (pipe_data[k+1])
    );
  end

  // ---- result shaping and output register --------------------------------
  stage_t       fin;
  logic [W-1:0] lo_nxt, hi_nxt;

  always_comb begin
    fin    = pipe_data[ITER_STAGES];
    lo_nxt = '0;
    hi_nxt = '0;
    case (fin.kind)
      KIND_ADD, KIND_SUB: begin
        lo_nxt = fin.sum_lo;
      end
      KIND_MUL: begin
        lo_nxt = fin.work.acc_lo;
        hi_nxt = fin.work.acc_hi[W-1:0];
      end
      KIND_DIV: begin
        lo_nxt = fin.neg_q ? (~fin.work.acc_lo + 1'b1) : fin.work.acc_lo;
        hi_nxt = fin.neg_r ? (~fin.work.acc_hi[W-1:0] + 1'b1)
                           : fin.work.acc_hi[W-1:0];
      end
      default: lo_nxt = '0;
    endcase
    if (fin.status != ST_OK) begin
      lo_nxt = '0;
      hi_nxt = '0;
    end
  end

  logic         out_valid_r;
  logic [W-1:0] out_lo_r, out_hi_r;
  logic [1:0]   out_status_r;

  assign pipe_ready[ITER_STAGES] = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_ready[ITER_STAGES]) begin
      out_valid_r <= pipe_valid[ITER_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_ready[ITER_STAGES] && pipe_valid[ITER_STAGES]) begin
      out_lo_r     <= lo_nxt;
      out_hi_r     <= hi_nxt;
      out_status_r <= fin.status;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.value_low  = out_lo_r;
  assign out_ch.value_high = out_hi_r;
  assign out_ch.status     = out_status_r;

endmodule

/* hdl/sabmd_iter_stage.sv */
// ----------------------------------------------------------------------------
// sabmd_iter_stage
// One pipeline stage: four Booth or restoring-divide steps, then a register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sabmd_iter_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  sabmd_pkg::stage_t up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output sabmd_pkg::stage_t dn_data
);
  import sabmd_pkg::*;

  logic   valid_r;
  stage_t data_r;
  stage_t data_nxt;

  always_comb begin
    data_nxt = up_data;
    for (int i = 0; i < STEPS_PER_STAGE; i++) begin
      data_nxt.work = iter_step(up_data.kind == KIND_MUL, data_nxt.work);
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

/* hdl/sabmd_chk.sv */
// ----------------------------------------------------------------------------
// sabmd_chk
// Port-level checks for the ALU, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "signed_add_sub_booth_mul_div_alu_unit_assert.svh"

module sabmd_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_value_low,
  input logic [15:0] out_value_high,
  input logic [1:0]  out_status
);
  import sabmd_pkg::*;

  // stalled result word holds
  `SABMD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value_low) && $stable(out_value_high) && $stable(out_status), "result word changed while stalled")

  // every error status carries zero values
  `SABMD_ASSERT_NOW(a_err_zero, out_valid && out_status != ST_OK, out_value_low == '0 && out_value_high == '0, "error word with nonzero value")

  // a free output side means the whole pipe moves, so input is open
  `SABMD_ASSERT_NOW(a_in_open, !out_valid || out_ready, in_ready, "input blocked while output side is free")

  // first cycle out of reset shows an empty output
  `SABMD_ASSERT_NOW(a_rst_empty, $past(!rst_n), !out_valid, "result valid right after reset")

endmodule

bind signed_add_sub_booth_mul_div_alu_unit sabmd_chk u_sabmd_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_value_low  (out_ch.value_low),
  .out_value_high (out_ch.value_high),
  .out_status     (out_ch.status)
);

/* sim/tb_signed_add_sub_booth_mul_div_alu_unit.sv */
// ----------------------------------------------------------------------------
// tb_signed_add_sub_booth_mul_div_alu_unit
// Self-checking bench for the 16-bit signed add/sub/multiply/divide ALU.
// A directed set hits the operand corners and every error case of each
// operation. Random words follow under three idle patterns on the two
// channels. Each accepted operation word is predicted in the bench. Result
// words are compared in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_signed_add_sub_booth_mul_div_alu_unit;
  import sabmd_pkg::*;

  // one operation word and one result word, at the channel widths
  typedef struct packed {
    logic [1:0]   kind;
    logic [W-1:0] operand_a;
    logic [W-1:0] operand_b;
  } alu_op_t;

  typedef struct packed {
    logic [W-1:0] value_low;
    logic [W-1:0] value_high;
    logic [1:0]   status;
  } alu_res_t;

  // Holds the expected result words, oldest first, and checks the
  // received words against them.
  class alu_result_board;
    alu_res_t pending_results[$];
    int       errors;

    // Integer arithmetic on sign-extended operands, then range checks.
    // Error cases leave both values at zero.
    function alu_res_t expected_alu_result(alu_op_t op);
      int       a;
      int       b;
      int       acc;
      alu_res_t r;
      a = $signed(op.operand_a);
      b = $signed(op.operand_b);
      r = '0;
      r.status = ST_OK;
      case (op.kind)
        KIND_ADD, KIND_SUB: begin
          // the most negative subtrahend has no 16-bit negation
          if (op.kind == KIND_SUB && b == -32768) begin
            r.status = ST_NEG;
          end else begin
            acc = (op.kind == KIND_ADD) ? a + b : a - b;
            if (acc > 32767 || acc < -32768) begin
              r.status = ST_OVF;
            end else begin
              r.value_low = acc[W-1:0];
            end
          end
        end
        KIND_MUL: begin
          acc          = a * b;
          r.value_low  = acc[W-1:0];
          r.value_high = acc[2*W-1:W];
        end
        default: begin
          if (b == 0 || (a == -32768 && b == -1)) begin
            r.status = ST_DIV;
          end else begin
            // int division truncates; remainder follows the dividend
            acc          = a / b;
            r.value_low  = acc[W-1:0];
            acc          = a % b;
            r.value_high = acc[W-1:0];
          end
        end
      endcase
      return r;
    endfunction

    function void note_operation(alu_op_t op);
      pending_results.push_back(expected_alu_result(op));
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    task report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
      errors++;
      if (errors <= 40)
        $display("%0t ns: mismatch on %s: got 0x%h, want 0x%h", $realtime, what, got, want);
    endtask

    task check_result(alu_res_t got);
      alu_res_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", {got.value_high[W-3:0], got.status}, '0);
      end else begin
        want = pending_results.pop_front();
        if (got.value_low !== want.value_low)
          report_mismatch("value_low", got.value_low, want.value_low);
        if (got.value_high !== want.value_high)
          report_mismatch("value_high", got.value_high, want.value_high);
        if (got.status !== want.status)
          report_mismatch("status", W'(got.status), W'(want.status));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  sabmd_in_if  in_ch ();
  sabmd_out_if out_ch ();

  signed_add_sub_booth_mul_div_alu_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  alu_result_board results_sb = new();

  // idle odds in percent, changed between phases
  int send_idle_pct;
  int recv_idle_pct;

  // 4 ns period
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // known values on every input from time zero
  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.kind      = KIND_ADD;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    out_ch.ready    = 1'b0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
  end

  // Receiver: ready is redrawn at every falling edge, so the stalls land
  // on any pipeline phase. Held low through reset.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result words are taken at the rising edge, before any update from it.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      results_sb.check_result('{out_ch.value_low, out_ch.value_high, out_ch.status});
  end

  function automatic alu_op_t make_op(logic [1:0] kind, logic [W-1:0] a, logic [W-1:0] b);
    alu_op_t op;
    op.kind      = kind;
    op.operand_a = a;
    op.operand_b = b;
    return op;
  endfunction

  // Operand mix: a good share of corners and small values, so that
  // overflow, the unnegatable subtrahend and both divide errors come up
  // often. Full random words make every bit toggle.
  function automatic logic [W-1:0] pick_operand();
    logic [W-1:0] v;
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(5))
          0:       v = 16'h8000;
          1:       v = 16'h7fff;
          2:       v = 16'hffff;
          3:       v = 16'h0000;
          4:       v = 16'h0001;
          default: v = 16'h8001;
        endcase
      end
      1: begin
        v = W'($urandom_range(16));
        v = v - 16'd8;
      end
      2:       v = W'($urandom_range(255)) ^ {W{$urandom_range(1) == 1}};
      default: v = W'($urandom);
    endcase
    return v;
  endfunction

  // Entered and left at a falling edge. Optional idle cycles first, then
  // the word is held until a rising edge sees ready high. The word is
  // noted as soon as it is accepted.
  task automatic send_op(alu_op_t op);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= op.kind;
    in_ch.operand_a <= op.operand_a;
    in_ch.operand_b <= op.operand_b;
    do
      @(posedge clk);
    while (!in_ch.ready);
    results_sb.note_operation(op);
    @(negedge clk);
  endtask

  task automatic send_random_ops(int count);
    for (int i = 0; i < count; i++)
      send_op(make_op(2'($urandom_range(3)), pick_operand(), pick_operand()));
  endtask

  // sender holds off until the pipeline has emptied out
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    while (results_sb.pending() != 0)
      @(negedge clk);
  endtask

  initial begin
    // reset held over the first rising edges, released at a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // phase one: sender mostly busy, receiver stalls heavily
    send_idle_pct = 14;
    recv_idle_pct = 74;

    // add: both overflow directions, the no-overflow extremes
    send_op(make_op(KIND_ADD, 16'h7fff, 16'h0001));
    send_op(make_op(KIND_ADD, 16'h8000, 16'hffff));
    send_op(make_op(KIND_ADD, 16'h8000, 16'h7fff));
    send_op(make_op(KIND_ADD, 16'hffff, 16'hffff));
    send_op(make_op(KIND_ADD, 16'h0000, 16'h0000));
    // subtract: minimum subtrahend wins over overflow, then overflows
    send_op(make_op(KIND_SUB, 16'h0000, 16'h8000));
    send_op(make_op(KIND_SUB, 16'hffff, 16'h8000));
    send_op(make_op(KIND_SUB, 16'h8000, 16'h0001));
    send_op(make_op(KIND_SUB, 16'h7fff, 16'hffff));
    send_op(make_op(KIND_SUB, 16'h0005, 16'h0003));
    // multiply: minimum multiplicand is legal, sign corners
    send_op(make_op(KIND_MUL, 16'h8000, 16'h8000));
    send_op(make_op(KIND_MUL, 16'h8000, 16'h7fff));
    send_op(make_op(KIND_MUL, 16'h8000, 16'h0001));
    send_op(make_op(KIND_MUL, 16'h7fff, 16'h7fff));
    send_op(make_op(KIND_MUL, 16'hffff, 16'hffff));
    send_op(make_op(KIND_MUL, 16'h0000, 16'h8000));
    // divide: zero divisor, minimum over minus one, truncation signs
    send_op(make_op(KIND_DIV, 16'h1234, 16'h0000));
    send_op(make_op(KIND_DIV, 16'h8000, 16'hffff));
    send_op(make_op(KIND_DIV, 16'h8000, 16'h0001));
    send_op(make_op(KIND_DIV, 16'h0007, 16'hfffe));
    send_op(make_op(KIND_DIV, 16'hfff9, 16'h0002));
    send_op(make_op(KIND_DIV, 16'hfff9, 16'hfffe));
    send_op(make_op(KIND_DIV, 16'h7fff, 16'h8000));
    send_op(make_op(KIND_DIV, 16'h8000, 16'h8000));
    send_op(make_op(KIND_DIV, 16'h0000, 16'h0005));

    send_random_ops(434);
    wait_for_drain();

    // phase two: sender idles often, receiver mostly ready
    send_idle_pct = 74;
    recv_idle_pct = 14;
    send_random_ops(433);
    wait_for_drain();

    // phase three: back to back on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_ops(433);
    wait_for_drain();

    // wait on for any stray word before the verdict
    repeat (12) @(negedge clk);
    if (results_sb.errors == 0 && results_sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // hard stop, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
